>>> hw/rtl/lpcr_pkg.sv
// shared types, constants and helpers of the lpc residual filter
`default_nettype none

package lpcr_pkg;

    localparam int MAX_TAPS    = 256;
    localparam int TAP_W       = $clog2(MAX_TAPS);
    localparam int ORDER_W     = 8;
    localparam int SMP_W       = 16;
    localparam int COEF_W      = 24;
    localparam int PROD_W      = SMP_W + COEF_W;
    localparam int ACC_W       = 48;
    localparam int RND_SHIFT   = 19;
    localparam int ORDER_CEIL  = 199;
    localparam int ORDER_RESET = 16;
    localparam int ORDER_LIMIT = (ORDER_CEIL < MAX_TAPS) ? ORDER_CEIL : MAX_TAPS;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int REG_W  = ADDR_W - 2;

    localparam logic [REG_W-1:0] REG_ORDER = REG_W'(0);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SRD,
        S_SWR,
        S_MAC,
        S_DRAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clr;
        logic tap_vld;
    } t_mac_ctl;

    function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] v);
        logic [ORDER_W-1:0] res;
        if (v == '0) begin
            res = ORDER_W'(1);
        end else if (v > ORDER_W'(ORDER_LIMIT)) begin
            res = ORDER_W'(ORDER_LIMIT);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lpc_residual_fir_filter.sv
// top level of the lpc prediction-error filter with coefficient and history memories
// a word runs a coefficient update (read, write) if its index is nonzero, then the tap loop
// over order taps, a drain and a finish that waits for a free output; no new word is taken
// before its result is loaded; the single mac takes a coefficient and a history read per tap
// reset and every order write start a pass clearing every entry of the coefficient memory
// input is stalled during that pass; history is gated by a fill count and needs no clearing
`default_nettype none

module lpc_residual_fir_filter
    import lpcr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic      [DATA_W-1:0]        prdata,
    output logic                          pready,

    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [SMP_W-1:0]  i_sample_in,
    input  wire logic signed [COEF_W-1:0] i_coeff_value,
    input  wire logic [ORDER_W-1:0]       i_coeff_index,

    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [SMP_W-1:0]       o_residual_out
);

    t_state r_state;
    t_state n_state;

    logic [TAP_W-1:0]          r_clr;
    logic [ORDER_W-1:0]        r_order;
    logic signed [SMP_W-1:0]   r_smp;
    logic signed [COEF_W-1:0]  r_cval;
    logic [ORDER_W-1:0]        r_cidx;
    logic                      r_copy;
    logic [TAP_W-1:0]          r_tap;
    logic [TAP_W-1:0]          r_wp;
    logic [TAP_W-1:0]          r_hcnt;
    logic                      r_rd_v;
    logic                      r_rd_hv;
    logic [TAP_W-1:0]          r_rd_tap;
    logic                      r_out_valid;
    logic signed [SMP_W-1:0]   r_out;

    // staging coefficient in the upper half, active in the lower half
    logic [2*COEF_W-1:0]       r_coef_mem [MAX_TAPS];
    logic [2*COEF_W-1:0]       r_coef_q;
    logic [SMP_W-1:0]          r_hist_mem [MAX_TAPS];
    logic [SMP_W-1:0]          r_hist_q;

    logic                      ord_wr;
    logic                      accept;
    logic                      out_free;
    logic                      out_load;
    logic                      coef_we;
    logic [TAP_W-1:0]          coef_waddr;
    logic [2*COEF_W-1:0]       coef_wdata;
    logic [TAP_W-1:0]          coef_raddr;
    logic [TAP_W-1:0]          hist_raddr;
    logic [TAP_W-1:0]          cidx_addr;
    logic signed [COEF_W-1:0]  tap_coeff;
    logic signed [SMP_W-1:0]   tap_smp;
    t_mac_ctl                  mac_ctl;
    logic                      mac_busy;
    logic signed [SMP_W-1:0]   residual;

    assign pready   = 1'b1;
    assign ord_wr   = psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_ORDER);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cidx_addr = TAP_W'(r_cidx - ORDER_W'(1));

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_ORDER) begin
            prdata = DATA_W'(r_order);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr == TAP_W'(MAX_TAPS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = (i_coeff_index != '0) ? S_SRD : S_MAC;
            end
            S_SRD: begin
                n_state = S_SWR;
            end
            S_SWR: begin
                n_state = S_MAC;
            end
            S_MAC: begin
                if (ORDER_W'(r_tap) == r_order - ORDER_W'(1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_rd_v && !mac_busy) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
        if (ord_wr) n_state = S_CLR;
    end

    // outputs of the sequencer
    always_comb begin
        accept          = 1'b0;
        out_load        = 1'b0;
        o_in_stall      = 1'b1;
        coef_raddr      = r_tap;
        mac_ctl.clr     = 1'b0;
        mac_ctl.tap_vld = r_rd_v;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                accept      = i_in_valid;
                mac_ctl.clr = i_in_valid;
            end
            S_SRD: begin
                coef_raddr = cidx_addr;
            end
            S_FIN: begin
                out_load = out_free;
            end
            default: begin
                coef_raddr = r_tap;
            end
        endcase

        coef_we    = 1'b0;
        coef_waddr = r_rd_tap;
        coef_wdata = {r_coef_q[2*COEF_W-1:COEF_W], r_coef_q[2*COEF_W-1:COEF_W]};
        priority if (r_state == S_CLR) begin
            coef_we    = 1'b1;
            coef_waddr = r_clr;
            coef_wdata = '0;
        end else if (r_state == S_SWR) begin
            coef_we    = 1'b1;
            coef_waddr = cidx_addr;
            coef_wdata = {r_cval, r_coef_q[COEF_W-1:0]};
        end else if (r_rd_v && r_copy) begin
            coef_we = 1'b1;
        end else begin
            coef_we = 1'b0;
        end
    end

    assign hist_raddr = r_wp - TAP_W'(1) - r_tap;

    // tap operands: staging value stands in for active while it is copied
    assign tap_coeff       = r_copy ? r_coef_q[2*COEF_W-1:COEF_W] : r_coef_q[COEF_W-1:0];
    assign tap_smp         = r_rd_hv ? r_hist_q : '0;

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= coef_wdata;
        end
        r_coef_q <= r_coef_mem[coef_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_hist_mem[r_wp] <= r_smp;
        end
        r_hist_q <= r_hist_mem[hist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_order     <= clamp_order(ORDER_W'(ORDER_RESET));
            r_wp        <= '0;
            r_hcnt      <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == S_MAC);
            if (ord_wr) begin
                r_order <= clamp_order(pwdata[ORDER_W-1:0]);
                r_clr   <= '0;
                r_wp    <= '0;
                r_hcnt  <= '0;
            end else begin
                if (r_state == S_CLR) begin
                    r_clr <= r_clr + TAP_W'(1);
                end
                if (out_load) begin
                    r_wp <= r_wp + TAP_W'(1);
                    if (r_hcnt != '1) begin
                        r_hcnt <= r_hcnt + TAP_W'(1);
                    end
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp  <= i_sample_in;
            r_cval <= i_coeff_value;
            r_cidx <= i_coeff_index;
            r_copy <= (i_coeff_index == r_order);
            r_tap  <= '0;
        end else if (r_state == S_MAC) begin
            r_tap <= r_tap + TAP_W'(1);
        end
        r_rd_tap <= r_tap;
        r_rd_hv  <= (r_tap < r_hcnt);
        if (out_load) begin
            r_out <= residual;
        end
    end

    lpcr_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_coeff    (tap_coeff),
        .i_tap_smp  (tap_smp),
        .i_smp      (r_smp),
        .o_busy     (mac_busy),
        .o_residual (residual)
    );

    assign o_out_valid    = r_out_valid;
    assign o_residual_out = r_out;

`ifndef NO_ASSERTIONS
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result word raised outside the finish step");

    a_copy_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_v && r_copy) |-> (ORDER_W'(r_rd_tap) < r_order))
        else $error("coefficient copy beyond the filter order");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_v && !mac_busy))
        else $error("tap pipeline still busy when a new word can enter");

    a_order_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ord_wr |=> (r_state == S_CLR && r_clr == '0 && r_hcnt == '0))
        else $error("order write did not start the clearing pass");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/lpcr_mac.sv
// multiply-accumulate pipeline with rounding and saturation of the residual
`default_nettype none

module lpcr_mac
    import lpcr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [COEF_W-1:0] i_coeff,
    input  wire logic signed [SMP_W-1:0]  i_tap_smp,
    input  wire logic signed [SMP_W-1:0]  i_smp,
    output logic                          o_busy,
    output logic signed [SMP_W-1:0]       o_residual
);

    localparam int ERR_W = ACC_W + 1;
    localparam int Q_W   = ERR_W - RND_SHIFT;

    // bias of half an lsb folded into the accumulator start value
    localparam logic signed [ACC_W-1:0] ACC_INIT = -(ACC_W'(2 ** (RND_SHIFT - 1)));
    localparam logic signed [Q_W-1:0]   Q_MAX    = Q_W'(2 ** (SMP_W - 1) - 1);
    localparam logic signed [Q_W-1:0]   Q_MIN    = -(Q_W'(2 ** (SMP_W - 1)));

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ERR_W-1:0]  err;
    logic signed [Q_W-1:0]    quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.tap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_coeff) * PROD_W'(i_tap_smp);
        if (i_ctl.clr) begin
            r_acc <= ACC_INIT;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_comb begin
        err = (ERR_W'(i_smp) <<< RND_SHIFT) - ERR_W'(r_acc);
        quo = err[ERR_W-1:RND_SHIFT];
        if (quo > Q_MAX) begin
            o_residual = Q_MAX[SMP_W-1:0];
        end else if (quo < Q_MIN) begin
            o_residual = Q_MIN[SMP_W-1:0];
        end else begin
            o_residual = quo[SMP_W-1:0];
        end
    end

    assign o_busy = i_ctl.tap_vld | r_pv;

endmodule

`default_nettype wire
